@@ rtl/core/fpfa_pkg.sv @@
package fpfa_pkg;

  localparam int unsigned PAGE_BITS = 12;
  localparam int unsigned MAX_PAGES = 4096;

  localparam int unsigned ADDR_W  = 56;
  localparam int unsigned PN_W    = ADDR_W - PAGE_BITS;
  localparam int unsigned START_W = PN_W + 1;
  localparam int unsigned PTR_W   = $clog2(MAX_PAGES);
  localparam int unsigned CNT_W   = 13;
  localparam int unsigned CMD_W   = 2;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned CFG_IDX_W = 1;

  typedef enum logic [CMD_W-1:0] {
    CMD_REBUILD = 2'd0,
    CMD_ALLOC   = 2'd1,
    CMD_FREE    = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_e;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_BAD_ADDR = 2'd2,
    ST_FULL     = 2'd3
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KERNEL_END = 1'd0,
    REG_PHYS_TOP   = 1'd1
  } reg_idx_e;

  typedef struct packed {
    cmd_e              cmd;
    logic [ADDR_W-1:0] free_addr;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_addr;
    status_e           status;
    logic [CNT_W-1:0]  free_count;
  } out_t;

  // pool bounds derived from the configuration registers
  typedef struct packed {
    logic [START_W-1:0] pool_start;
    logic [ADDR_W-1:0]  phys_top;
  } pool_cfg_t;

endpackage

@@ rtl/core/fpfa_ram.sv @@
module fpfa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/fpfa_ctrl.sv @@
module fpfa_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  fpfa_pkg::pool_cfg_t cfg_i,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  fpfa_pkg::in_t       in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output fpfa_pkg::out_t      out_data_o,
  output logic                mem_we_o,
  output logic [fpfa_pkg::PTR_W-1:0] mem_waddr_o,
  output logic [fpfa_pkg::PN_W-1:0]  mem_wdata_o,
  output logic                mem_re_o,
  output logic [fpfa_pkg::PTR_W-1:0] mem_raddr_o,
  input  logic [fpfa_pkg::PN_W-1:0]  mem_rdata_i
);
  import fpfa_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_READ
  } state_e;

  function automatic logic [PTR_W-1:0] ring_next(input logic [PTR_W-1:0] p);
    ring_next = (p == PTR_W'(MAX_PAGES - 1)) ? '0 : p + 1'b1;
  endfunction

  state_e             state_q, state_d;
  logic [START_W-1:0] fresh_next_q, fresh_next_d;
  logic [START_W-1:0] fresh_end_q, fresh_end_d;
  logic [PTR_W-1:0]   head_q, head_d;
  logic [PTR_W-1:0]   tail_q, tail_d;
  logic [CNT_W-1:0]   queued_q, queued_d;
  logic [CNT_W-1:0]   free_total_q, free_total_d;
  logic               out_valid_q, out_valid_d;
  out_t               out_q, out_d;

  logic               accept;
  logic               slot_free;
  logic [PN_W-1:0]    end_page;
  logic [START_W-1:0] span;
  logic               span_pos;
  logic               span_big;
  logic [PN_W-1:0]    free_pg;
  logic               bad_addr;
  logic               full;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = !((state_q == S_IDLE) && slot_free);
  assign accept     = in_valid_i && !in_stall_o;

  assign end_page = cfg_i.phys_top[ADDR_W-1:PAGE_BITS];
  assign span_pos = {1'b0, end_page} > cfg_i.pool_start;
  assign span     = {1'b0, end_page} - cfg_i.pool_start;
  assign span_big = span > START_W'(MAX_PAGES);

  assign free_pg  = in_data_i.free_addr[ADDR_W-1:PAGE_BITS];
  assign bad_addr = (in_data_i.free_addr == '0)
                 || (in_data_i.free_addr[PAGE_BITS-1:0] != '0)
                 || ({1'b0, free_pg} < cfg_i.pool_start)
                 || (in_data_i.free_addr >= cfg_i.phys_top);
  assign full     = (free_total_q >= CNT_W'(MAX_PAGES)) || (queued_q >= CNT_W'(MAX_PAGES));

  always_comb begin
    state_d      = state_q;
    fresh_next_d = fresh_next_q;
    fresh_end_d  = fresh_end_q;
    head_d       = head_q;
    tail_d       = tail_q;
    queued_d     = queued_q;
    free_total_d = free_total_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_d        = out_q;
    mem_we_o     = 1'b0;
    mem_re_o     = 1'b0;
    mem_waddr_o  = tail_q;
    mem_wdata_o  = free_pg;
    mem_raddr_o  = head_q;

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          out_d.page_addr = '0;
          out_d.status    = ST_OK;
          out_valid_d     = 1'b1;
          case (in_data_i.cmd)
            CMD_REBUILD: begin
              fresh_next_d = cfg_i.pool_start;
              head_d       = '0;
              tail_d       = '0;
              queued_d     = '0;
              if (!span_pos) begin
                fresh_end_d  = cfg_i.pool_start;
                free_total_d = '0;
              end else if (span_big) begin
                fresh_end_d  = cfg_i.pool_start + START_W'(MAX_PAGES);
                free_total_d = CNT_W'(MAX_PAGES);
              end else begin
                fresh_end_d  = {1'b0, end_page};
                free_total_d = span[CNT_W-1:0];
              end
            end
            CMD_ALLOC: begin
              if (fresh_next_q < fresh_end_q) begin
                out_d.page_addr = {fresh_next_q[PN_W-1:0], {PAGE_BITS{1'b0}}};
                fresh_next_d    = fresh_next_q + 1'b1;
                free_total_d    = free_total_q - 1'b1;
              end else if (queued_q != '0) begin
                mem_re_o     = 1'b1;
                head_d       = ring_next(head_q);
                queued_d     = queued_q - 1'b1;
                free_total_d = free_total_q - 1'b1;
                out_valid_d  = 1'b0;
                state_d      = S_READ;
              end else begin
                out_d.status = ST_EMPTY;
              end
            end
            CMD_FREE: begin
              if (bad_addr) begin
                out_d.status = ST_BAD_ADDR;
              end else if (full) begin
                out_d.status = ST_FULL;
              end else begin
                mem_we_o     = 1'b1;
                tail_d       = ring_next(tail_q);
                queued_d     = queued_q + 1'b1;
                free_total_d = free_total_q + 1'b1;
              end
            end
            default: ;
          endcase
          out_d.free_count = free_total_d;
        end
      end
      S_READ: begin
        out_d.page_addr  = {mem_rdata_i, {PAGE_BITS{1'b0}}};
        out_d.status     = ST_OK;
        out_d.free_count = free_total_q;
        out_valid_d      = 1'b1;
        state_d          = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      fresh_next_q <= '0;
      fresh_end_q  <= '0;
      head_q       <= '0;
      tail_q       <= '0;
      queued_q     <= '0;
      free_total_q <= '0;
      out_valid_q  <= 1'b0;
      out_q        <= '0;
    end else begin
      state_q      <= state_d;
      fresh_next_q <= fresh_next_d;
      fresh_end_q  <= fresh_end_d;
      head_q       <= head_d;
      tail_q       <= tail_d;
      queued_q     <= queued_d;
      free_total_q <= free_total_d;
      out_valid_q  <= out_valid_d;
      out_q        <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  a_queued_le_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    queued_q <= free_total_q) else $error("queued pages exceed free total");

  a_total_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    free_total_q <= CNT_W'(MAX_PAGES)) else $error("free total above pool cap");

  a_read_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |-> !out_valid_q) else $error("queue read with result pending");

  a_read_one_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_READ |=> state_q == S_IDLE && out_valid_q)
    else $error("queue read did not complete");

endmodule

@@ rtl/core/fifo_page_frame_allocator.sv @@
// Page-frame allocator with first-in first-out reuse. Command 0 rebuilds the
// pool from the page after the rounded-up kernel end up to the top address,
// 1 allocates a page and 2 frees one; every command gives exactly one result
// transfer. Fresh pages go out in ascending order before any freed page;
// freed pages come back in the order they were freed. A rebuild, a fresh
// allocation or a free gives its result in the next cycle; an allocation from
// the freed queue passes the queue RAM's read register and then the result
// register. One command is in flight at a time, but a new one is taken while
// the previous result is being transferred. The user writes configuration
// registers only while idle, unenforced. No clearing pass follows reset.
module fifo_page_frame_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [fpfa_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [fpfa_pkg::ADDR_W-1:0]         cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  fpfa_pkg::in_t                       in_data_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output fpfa_pkg::out_t                      out_data_o
);
  import fpfa_pkg::*;

  pool_cfg_t          cfg_q;
  logic [START_W-1:0] start_d;

  logic               mem_we;
  logic [PTR_W-1:0]   mem_waddr;
  logic [PN_W-1:0]    mem_wdata;
  logic               mem_re;
  logic [PTR_W-1:0]   mem_raddr;
  logic [PN_W-1:0]    mem_rdata;

  // first pool page: kernel end rounded up to a page, plus one
  assign start_d = {1'b0, cfg_wdata_i[ADDR_W-1:PAGE_BITS]}
                 + START_W'(cfg_wdata_i[PAGE_BITS-1:0] != '0) + 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pool_start <= START_W'(1);
      cfg_q.phys_top   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_KERNEL_END: cfg_q.pool_start <= start_d;
        REG_PHYS_TOP:   cfg_q.phys_top   <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  fpfa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_wdata_o (mem_wdata),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .mem_rdata_i (mem_rdata)
  );

  fpfa_ram #(
    .WIDTH (PN_W),
    .DEPTH (MAX_PAGES)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (mem_wdata),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (mem_rdata)
  );

endmodule
